/* sv/crpr_pkg.sv */
// shared types, codes and reply tables of the cashless reader responder
package crpr_pkg;

  localparam int MaxReplyBytesDef = 34;
  localparam logic [15:0] MaxAmountRst = 16'd65000;

  // host command codes
  localparam logic [2:0] OP_RESET  = 3'd0;
  localparam logic [2:0] OP_SETUP  = 3'd1;
  localparam logic [2:0] OP_POLL   = 3'd2;
  localparam logic [2:0] OP_VEND   = 3'd3;
  localparam logic [2:0] OP_READER = 3'd4;
  localparam logic [2:0] OP_EXPAN  = 3'd5;

  // mode codes
  localparam logic [2:0] M_INACTIVE = 3'd0;
  localparam logic [2:0] M_DISABLED = 3'd1;
  localparam logic [2:0] M_ENABLED  = 3'd2;
  localparam logic [2:0] M_IDLE     = 3'd3;
  localparam logic [2:0] M_VEND     = 3'd4;

  // vend outcome codes
  localparam logic [1:0] O_NOTHING = 2'd0;
  localparam logic [1:0] O_CANCEL  = 2'd1;
  localparam logic [1:0] O_SUCCESS = 2'd2;
  localparam logic [1:0] O_FAILURE = 2'd3;

  // deferred reply codes
  localparam logic [2:0] D_NONE       = 3'd0;
  localparam logic [2:0] D_JUST_RESET = 3'd1;
  localparam logic [2:0] D_CONFIG     = 3'd2;
  localparam logic [2:0] D_ID         = 3'd3;
  localparam logic [2:0] D_EXP_ID     = 3'd4;
  localparam logic [2:0] D_OUT_SEQ    = 3'd5;
  localparam logic [2:0] D_DISPLAY    = 3'd6;

  // reply frame kinds handed from front to back
  localparam logic [3:0] F_ACK        = 4'd0;
  localparam logic [3:0] F_JUST_RESET = 4'd1;
  localparam logic [3:0] F_CONFIG     = 4'd2;
  localparam logic [3:0] F_ID         = 4'd3;
  localparam logic [3:0] F_EXP_ID     = 4'd4;
  localparam logic [3:0] F_OUT_SEQ    = 4'd5;
  localparam logic [3:0] F_DISPLAY    = 4'd6;
  localparam logic [3:0] F_CANCEL     = 4'd7;
  localparam logic [3:0] F_END        = 4'd8;
  localparam logic [3:0] F_MONEY      = 4'd9;

  localparam logic [1:0] N_NONE  = 2'd0;
  localparam logic [1:0] N_POWER = 2'd1;
  localparam logic [1:0] N_PRICE = 2'd2;

  // one queued reply job
  typedef struct packed {
    logic [3:0]  kind;
    logic [7:0]  head;
    logic [15:0] amount;
    logic [1:0]  note;
    logic [15:0] note_price;
  } job_t;

  // frame length in bytes
  function automatic logic [5:0] frame_len(input logic [3:0] kind);
    logic [5:0] n;
    case (kind)
      F_ACK:        n = 6'd1;
      F_JUST_RESET: n = 6'd2;
      F_CONFIG:     n = 6'd9;
      F_ID:         n = 6'd31;
      F_EXP_ID:     n = 6'd4;
      F_OUT_SEQ:    n = 6'd2;
      F_DISPLAY:    n = 6'd34;
      F_CANCEL:     n = 6'd2;
      F_END:        n = 6'd2;
      F_MONEY:      n = 6'd4;
      default:      n = 6'd1;
    endcase
    return n;
  endfunction

  // identity table
  function automatic logic [7:0] id_byte(input logic [4:0] i);
    logic [7:0] b;
    case (i)
      5'd0: b = 8'h09;  5'd1: b = 8'h43;  5'd2: b = 8'h4F;  5'd3: b = 8'h4D;
      5'd4, 5'd5, 5'd6, 5'd7, 5'd8, 5'd9: b = 8'h30;
      5'd10: b = 8'h31; 5'd11: b = 8'h34; 5'd12: b = 8'h35; 5'd13: b = 8'h33;
      5'd14: b = 8'h38; 5'd15: b = 8'h36; 5'd16: b = 8'h4E; 5'd17: b = 8'h45;
      5'd18: b = 8'h57; 5'd19: b = 8'h5F; 5'd20: b = 8'h45; 5'd21: b = 8'h55;
      5'd22: b = 8'h52; 5'd23: b = 8'h4F; 5'd24: b = 8'h4B; 5'd25: b = 8'h45;
      5'd26: b = 8'h59; 5'd27: b = 8'h20; 5'd28: b = 8'h02; 5'd29: b = 8'h01;
      5'd30: b = 8'hD3;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // display table
  function automatic logic [7:0] disp_byte(input logic [5:0] i);
    logic [7:0] b;
    case (i)
      6'd0: b = 8'h02;  6'd1: b = 8'd100; 6'd2: b = 8'h2E;  6'd3: b = 8'h36;
      6'd4: b = 8'h39;  6'd5: b = 8'h3D;  6'd6: b = 8'h42;  6'd7: b = 8'h14;
      6'd8: b = 8'h3C;  6'd9: b = 8'h35;  6'd10: b = 8'h38; 6'd11: b = 8'h3D;
      6'd33: b = 8'h00;
      default: b = 8'h14;
    endcase
    return b;
  endfunction

  // config table
  function automatic logic [7:0] cfg_byte(input logic [3:0] i);
    logic [7:0] b;
    case (i)
      4'd0, 4'd1, 4'd4: b = 8'h01;
      4'd2: b = 8'h2A;
      4'd3: b = 8'h11;
      4'd6: b = 8'h0A;
      4'd8: b = 8'h48;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // one byte of any frame
  function automatic logic [7:0] frame_byte(input job_t j, input logic [5:0] i);
    logic [7:0] b;
    logic [7:0] sum;
    sum = j.head + j.amount[15:8] + j.amount[7:0];
    case (j.kind)
      F_CONFIG:  b = cfg_byte(i[3:0]);
      F_ID:      b = id_byte(i[4:0]);
      F_EXP_ID: begin
        case (i[1:0])
          2'd0: b = 8'h01;
          2'd1: b = 8'h02;
          2'd2: b = 8'hFF;
          default: b = 8'h02;
        endcase
      end
      F_OUT_SEQ: b = 8'h0B;
      F_DISPLAY: b = disp_byte(i);
      F_CANCEL:  b = 8'h04;
      F_END:     b = 8'h07;
      F_MONEY: begin
        case (i[1:0])
          2'd0: b = j.head;
          2'd1: b = j.amount[15:8];
          2'd2: b = j.amount[7:0];
          default: b = sum;
        endcase
      end
      default:   b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

/* sv/crpr_cmd_if.sv */
// command and reply channel interfaces
interface crpr_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [7:0]  sub_command;
  logic [15:0] price;
  logic [23:0] balance_in;
  modport source (output valid, op, sub_command, price, balance_in, input ready);
  modport sink (input valid, op, sub_command, price, balance_in, output ready);
endinterface

interface crpr_rsp_if;
  logic        valid;
  logic        ready;
  logic [7:0]  reply_byte;
  logic        last;
  logic [1:0]  notify;
  logic [15:0] notify_price;
  modport source (output valid, reply_byte, last, notify, notify_price, input ready);
  modport sink (input valid, reply_byte, last, notify, notify_price, output ready);
endinterface

/* sv/crpr_front.sv */
// command decoder and protocol state holder
module crpr_front
  import crpr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        cmd_valid,
  output logic        cmd_ready,
  input  logic [2:0]  op,
  input  logic [7:0]  sub_command,
  input  logic [15:0] price,
  input  logic [23:0] balance_in,
  output logic        job_valid,
  input  logic        job_ready,
  output job_t        job
);

  logic [15:0] max_amount_r;
  logic [2:0]  mode_r, mode_nxt;
  logic [2:0]  pend_r, pend_nxt;
  logic [2:0]  defer_r, defer_nxt;
  logic [15:0] bal_r, bal_nxt;
  logic [15:0] cost_r, cost_nxt;
  logic [1:0]  outc_r, outc_nxt;
  logic        emit;
  logic [15:0] clip;

  // a transaction is taken only when the queue has room for its reply
  assign cmd_ready = job_ready;
  assign job_valid = cmd_valid && job_ready && emit;
  assign clip = (balance_in > {8'd0, max_amount_r}) ? max_amount_r : balance_in[15:0];

  // command decode
  always_comb begin
    mode_nxt = mode_r; pend_nxt = pend_r; defer_nxt = defer_r;
    bal_nxt = bal_r; cost_nxt = cost_r; outc_nxt = outc_r;
    emit = 1'b0;
    job = '{kind: F_ACK, head: 8'h00, amount: 16'd0, note: N_NONE, note_price: 16'd0};
    if (op == OP_RESET && mode_r <= M_VEND) begin
      defer_nxt = D_JUST_RESET; mode_nxt = M_INACTIVE; emit = 1'b1;
    end else begin
      unique case (mode_r)
        M_INACTIVE: begin
          if (op == OP_POLL) begin
            emit = 1'b1;
            if (defer_r != D_NONE) begin
              job.kind = {1'b0, defer_r}; defer_nxt = D_NONE;
              if (pend_r != M_INACTIVE) begin
                mode_nxt = pend_r; pend_nxt = M_INACTIVE;
              end
            end
          end else if (op == OP_SETUP) begin
            if (sub_command == 8'd0) begin
              defer_nxt = D_CONFIG; emit = 1'b1;
            end else if (sub_command == 8'd1) emit = 1'b1;
          end else if (op == OP_EXPAN && sub_command == 8'd0) begin
            defer_nxt = D_ID; pend_nxt = M_DISABLED; emit = 1'b1;
          end
        end
        M_DISABLED: begin
          if (op == OP_POLL) begin
            emit = 1'b1;
            if (defer_r != D_NONE) begin
              job.kind = {1'b0, defer_r}; defer_nxt = D_NONE;
            end
          end else if (op == OP_READER) begin
            if (sub_command == 8'd1) begin
              mode_nxt = M_ENABLED; emit = 1'b1; job.note = N_POWER;
            end else if (sub_command == 8'd0) emit = 1'b1;
            else if (sub_command == 8'd2) defer_nxt = D_OUT_SEQ;
          end else if (op == OP_EXPAN && sub_command == 8'd0) begin
            defer_nxt = D_EXP_ID; emit = 1'b1;
          end
        end
        M_ENABLED: begin
          if (op == OP_POLL) begin
            emit = 1'b1;
            if (balance_in != 24'd0) begin
              bal_nxt = clip; outc_nxt = O_NOTHING; mode_nxt = M_IDLE;
              job.kind = F_MONEY; job.head = 8'h03; job.amount = clip;
            end
          end else if (op == OP_READER) begin
            if (sub_command == 8'd0) begin
              defer_nxt = D_DISPLAY; emit = 1'b1;
            end else if (sub_command == 8'd1) emit = 1'b1;
          end
        end
        M_IDLE: begin
          if (op == OP_VEND) begin
            if (sub_command == 8'd0) begin
              cost_nxt = price; mode_nxt = M_VEND; emit = 1'b1;
            end else if (sub_command == 8'd1 || sub_command == 8'd4) emit = 1'b1;
          end else if (op == OP_POLL) begin
            case (outc_r)
              O_NOTHING: emit = 1'b1;
              O_CANCEL: begin
                emit = 1'b1; job.kind = F_CANCEL;
              end
              O_SUCCESS: begin
                emit = 1'b1; job.kind = F_END; mode_nxt = M_ENABLED;
                job.note = N_PRICE; job.note_price = cost_r;
              end
              default: emit = 1'b0;
            endcase
          end
        end
        M_VEND: begin
          if (op == OP_POLL) begin
            bal_nxt = bal_r - cost_r; emit = 1'b1;
            job.kind = F_MONEY; job.head = 8'h05; job.amount = bal_r - cost_r;
          end else if (op == OP_VEND) begin
            case (sub_command)
              8'd1: begin
                outc_nxt = O_CANCEL; emit = 1'b1;
              end
              8'd2, 8'd4: begin
                mode_nxt = M_IDLE; outc_nxt = O_SUCCESS; emit = 1'b1;
              end
              8'd3: begin
                outc_nxt = O_FAILURE; bal_nxt = bal_r + cost_r; emit = 1'b1;
              end
              default: emit = 1'b0;
            endcase
          end
        end
        default: emit = 1'b0;
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_amount_r <= MaxAmountRst;
      mode_r <= M_INACTIVE; pend_r <= M_INACTIVE; defer_r <= D_NONE;
      bal_r <= 16'd0; cost_r <= 16'd0; outc_r <= O_NOTHING;
    end else begin
      if (cfg_we) max_amount_r <= cfg_wdata;
      if (cmd_valid && cmd_ready) begin
        mode_r <= mode_nxt; pend_r <= pend_nxt; defer_r <= defer_nxt;
        bal_r <= bal_nxt; cost_r <= cost_nxt; outc_r <= outc_nxt;
      end
    end
  end

endmodule

/* sv/crpr_queue.sv */
// small job queue between decoder and byte sender
module crpr_queue
  import crpr_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_v,
  output logic in_r,
  input  job_t in_d,
  output logic out_v,
  input  logic out_r,
  output job_t out_d
);

  job_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign in_r  = (cnt_r != 2'd2);
  assign out_v = (cnt_r != 2'd0);
  assign out_d = mem_r[rp_r];

  // storage
  always_ff @(posedge clk) begin
    if (in_v && in_r) mem_r[wp_r] <= in_d;
  end

  // pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (in_v && in_r) wp_r <= ~wp_r;
      if (out_v && out_r) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, in_v && in_r} - {1'b0, out_v && out_r};
    end
  end

endmodule

/* sv/crpr_back.sv */
// reply byte sender with registered output
module crpr_back
  import crpr_pkg::*;
#(
  parameter int MaxReplyBytes = MaxReplyBytesDef
) (
  input  logic clk,
  input  logic rst_n,
  input  logic job_valid,
  output logic job_ready,
  input  job_t job,
  crpr_rsp_if.source rsp
);

  localparam int IdxW = $clog2(MaxReplyBytes + 1);

  logic [IdxW-1:0] idx_r;
  logic [IdxW-1:0] len;
  logic            is_last;
  logic            load;
  logic            ovalid_r;
  logic [7:0]      byte_r;
  logic            last_r;
  logic [1:0]      note_r;
  logic [15:0]     nprice_r;

  assign len = IdxW'(frame_len(job.kind));
  assign is_last = (idx_r == len - IdxW'(1));
  assign load = job_valid && (!ovalid_r || rsp.ready);
  assign job_ready = load && is_last;

  assign rsp.valid = ovalid_r;
  assign rsp.reply_byte = byte_r;
  assign rsp.last = last_r;
  assign rsp.notify = note_r;
  assign rsp.notify_price = nprice_r;

  // byte index walk
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0; ovalid_r <= 1'b0;
    end else begin
      if (load) idx_r <= is_last ? '0 : idx_r + IdxW'(1);
      if (load) ovalid_r <= 1'b1;
      else if (rsp.ready) ovalid_r <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (load) begin
      byte_r   <= frame_byte(job, 6'(idx_r));
      last_r   <= is_last;
      note_r   <= job.note;
      nprice_r <= job.note_price;
    end
  end

endmodule

/* sv/cashless_reader_protocol_responder.sv */
// cashless reader responder: command decode, job queue and reply sender
// path: each reply job is registered in the job queue, then each reply byte in the output register
// throughput: one reply byte per cycle while the receiver is ready; replies are 1 to 34
//   bytes long, and a command with no reply queues no job
// reset: synchronous active-low, mode inactive, max_amount 65000, queue empty
module cashless_reader_protocol_responder
  import crpr_pkg::*;
#(
  parameter int MaxReplyBytes = MaxReplyBytesDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  crpr_cmd_if.sink    in_ch,
  crpr_rsp_if.source  out_ch
);

  logic f_v, f_r, b_v, b_r;
  job_t f_d, b_d;

  crpr_front u_front (
    .clk, .rst_n, .cfg_we, .cfg_wdata,
    .cmd_valid(in_ch.valid), .cmd_ready(in_ch.ready),
    .op(in_ch.op), .sub_command(in_ch.sub_command),
    .price(in_ch.price), .balance_in(in_ch.balance_in),
    .job_valid(f_v), .job_ready(f_r), .job(f_d)
  );

  crpr_queue u_queue (
    .clk, .rst_n, .in_v(f_v), .in_r(f_r), .in_d(f_d),
    .out_v(b_v), .out_r(b_r), .out_d(b_d)
  );

  crpr_back #(.MaxReplyBytes(MaxReplyBytes)) u_back (
    .clk, .rst_n, .job_valid(b_v), .job_ready(b_r), .job(b_d), .rsp(out_ch)
  );

endmodule
